@@ hw/rtl/tthc_pkg.sv @@
// Package: shared types, constants and helper functions for the Tanimoto hit counter.
package tthc_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int FP_WORDS        = 4;
    localparam int FP_BITS         = FP_WORDS * 64;
    localparam int WSEL_W          = $clog2(FP_WORDS);
    localparam int POP_W           = $clog2(FP_BITS + 1);
    localparam int BIN_COUNT       = FP_BITS + 1;
    localparam int CFG_W           = 10;
    localparam int OUT_CNT_W       = 13;
    localparam int DIV_W           = 19;
    localparam int MUL_W           = 2 * CFG_W;

    localparam logic [CFG_W-1:0] NUM_RESET = CFG_W'(7);
    localparam logic [CFG_W-1:0] DEN_RESET = CFG_W'(10);

    // Mode codes of an input item
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_ORDER = 2'd2;

    // Register indexes on the APB port
    localparam logic REG_NUM = 1'b0;
    localparam logic REG_DEN = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] row_id;
        logic [63:0] fp_word_0;
        logic [63:0] fp_word_1;
        logic [63:0] fp_word_2;
        logic [63:0] fp_word_3;
    } t_in;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] hit_count;
        logic [1:0]           status;
        logic [OUT_CNT_W-1:0] rows_stored;
    } t_out;

    // Population count of one 64-bit word
    function automatic logic [6:0] pop64(input logic [63:0] v);
        logic [6:0] c;
        c = '0;
        for (int i = 0; i < 64; i++) begin
            c = c + 7'(v[i]);
        end
        return c;
    endfunction

    // One fingerprint word of an input item
    function automatic logic [63:0] fp_word(input t_in it, input logic [WSEL_W-1:0] w);
        logic [63:0] r;
        case (w)
            2'd0:    r = it.fp_word_0;
            2'd1:    r = it.fp_word_1;
            2'd2:    r = it.fp_word_2;
            default: r = it.fp_word_3;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/tanimoto_threshold_hit_counter.sv @@
// Top level: Tanimoto threshold hit counter with a popcount-sorted fingerprint table.
//
//  channel   | ports                                   | transfer
//  ----------+-----------------------------------------+-------------------------------
//  command   | start, busy, i_item                     | start high while busy low
//  result    | o_result_valid, o_result                | one cycle strobe, no back-pressure
//  config    | psel penable pwrite paddr pwdata prdata | psel & penable & pwrite, pready=1
//
//  A query runs two 19-step divisions for the window bounds; if the window is not empty,
//  it reads one bin memory word per popcount up to hi, then per row four fingerprint memory
//  words through the shared 64-bit popcount unit.
//  Synchronous active-low reset clears the bin valid bits, the row counter and the sequencer.
//  busy stays high for the whole item; results cannot be stalled.
module tanimoto_threshold_hit_counter
    import tthc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in         i_item,
    output logic        o_result_valid,
    output t_out        o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int BW = $clog2(BIN_COUNT);

    typedef enum logic [4:0] {
        S_IDLE, S_POP, S_DISP, S_LDW, S_LDB_RD, S_LDB_WR, S_MQ, S_DIV, S_WIN,
        S_BIN, S_BIN_TAIL, S_ROW, S_ACC, S_MA, S_MB, S_CMP, S_DONE
    } t_state;

    t_state               r_state;
    t_in                  r_item;
    logic [CFG_W-1:0]     r_num, r_den;
    logic [CW-1:0]        r_cnt, r_hits, r_r, r_begin, r_end;
    logic [POP_W-1:0]     r_q, r_last, r_inter, r_hi;
    logic [WSEL_W:0]      r_w;
    logic [1:0]           r_status;
    logic                 r_sel;
    logic [DIV_W-1:0]     r_dvd, r_lo;
    logic [CFG_W-1:0]     r_rem;
    logic [4:0]           r_dcnt;
    logic [BW-1:0]        r_p, r_pd;
    logic                 r_pdv, r_bv_d;
    logic [BIN_COUNT-1:0] r_bin_vld;
    logic [MUL_W-1:0]     r_pa, r_pb;
    logic [CFG_W-1:0]     r_uni;
    logic                 r_res_vld;
    t_out                 r_res;

    // Memories and their registered read data
    logic [63:0]      fp_mem  [TABLE_DEPTH * FP_WORDS];
    logic [63:0]      id_mem  [TABLE_DEPTH];
    logic [POP_W-1:0] pc_mem  [TABLE_DEPTH];
    logic [CW-1:0]    bin_mem [BIN_COUNT];
    logic [63:0]      r_fp_rd, r_id_rd;
    logic [POP_W-1:0] r_pc_rd;
    logic [CW-1:0]    r_bin_rd;

    logic [CFG_W-1:0]  w_num_eff, w_den_eff, w_divisor;
    logic [WSEL_W-1:0] w_wsel;
    logic [63:0]       w_pop_in;
    logic [6:0]        w_pop;
    logic [CFG_W-1:0]  w_mul_a, w_mul_b;
    logic [MUL_W-1:0]  w_mul;
    logic [CFG_W:0]    w_trial;
    logic              w_qbit;
    logic [DIV_W-1:0]  w_quot;
    logic [CW-1:0]     w_bin_val, w_beg_sum, w_end_sum;
    logic [BW-1:0]     w_bin_addr;
    logic [CW-1:0]     w_bin_wdata;
    logic [CFG_W-1:0]  w_uni;
    logic              w_cfg_wr;

    // Zero register values count as one
    assign w_num_eff = (r_num == '0) ? CFG_W'(1) : r_num;
    assign w_den_eff = (r_den == '0) ? CFG_W'(1) : r_den;

    // Shared popcount unit: query words, or query AND stored word
    assign w_wsel   = (r_state == S_POP) ? r_w[WSEL_W-1:0] : (r_w[WSEL_W-1:0] - 1'b1);
    assign w_pop_in = (r_state == S_POP) ? fp_word(r_item, w_wsel)
                                         : (fp_word(r_item, w_wsel) & r_fp_rd);
    assign w_pop    = pop64(w_pop_in);

    // Shared multiplier
    always_comb begin
        case (r_state)
            S_MA: begin
                w_mul_a = w_den_eff;
                w_mul_b = CFG_W'(r_inter);
            end
            S_MB: begin
                w_mul_a = w_num_eff;
                w_mul_b = r_uni;
            end
            default: begin
                w_mul_a = r_sel ? w_den_eff : w_num_eff;
                w_mul_b = CFG_W'(r_q);
            end
        endcase
    end
    assign w_mul = w_mul_a * w_mul_b;

    // Restoring divider step
    assign w_divisor = r_sel ? w_num_eff : w_den_eff;
    assign w_trial   = {r_rem, r_dvd[DIV_W-1]};
    assign w_qbit    = (w_trial >= {1'b0, w_divisor});
    assign w_quot    = {r_dvd[DIV_W-2:0], w_qbit};

    // Bin sweep accumulation
    assign w_bin_val = (r_pdv && r_bv_d) ? r_bin_rd : '0;
    assign w_beg_sum = r_begin + (((DIV_W'(r_pd)) < r_lo) ? w_bin_val : '0);
    assign w_end_sum = r_end + w_bin_val;

    assign w_bin_addr  = (r_state == S_BIN) ? r_p : BW'(r_q);
    assign w_bin_wdata = (r_bv_d ? r_bin_rd : '0) + 1'b1;

    // Union, with an empty union taken as one
    always_comb begin
        w_uni = CFG_W'(r_q) + CFG_W'(r_pc_rd) - CFG_W'(r_inter);
        if (w_uni == '0) begin
            w_uni = CFG_W'(1);
        end
    end

    // Fingerprint, id and popcount memories
    always_ff @(posedge i_clk) begin
        if (r_state == S_LDW) begin
            fp_mem[{r_cnt[RW-1:0], r_w[WSEL_W-1:0]}] <= fp_word(r_item, r_w[WSEL_W-1:0]);
            if (r_w == '0) begin
                id_mem[r_cnt[RW-1:0]] <= r_item.row_id;
                pc_mem[r_cnt[RW-1:0]] <= r_q;
            end
        end
        r_fp_rd <= fp_mem[{r_r[RW-1:0], r_w[WSEL_W-1:0]}];
        r_id_rd <= id_mem[r_r[RW-1:0]];
        r_pc_rd <= pc_mem[r_r[RW-1:0]];
    end

    // Popcount bin memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_LDB_WR) begin
            bin_mem[BW'(r_q)] <= w_bin_wdata;
        end
        r_bin_rd <= bin_mem[w_bin_addr];
    end

    // APB port
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_DEN) ? 32'(r_den) : 32'(r_num);

    // Sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_num     <= NUM_RESET;
            r_den     <= DEN_RESET;
            r_cnt     <= '0;
            r_last    <= '0;
            r_bin_vld <= '0;
            r_res_vld <= 1'b0;
            r_pdv     <= 1'b0;
        end else begin
            r_res_vld <= 1'b0;
            if (w_cfg_wr) begin
                if (paddr[2] == REG_NUM) begin
                    r_num <= pwdata[CFG_W-1:0];
                end else begin
                    r_den <= pwdata[CFG_W-1:0];
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_item   <= i_item;
                        r_q      <= '0;
                        r_w      <= '0;
                        r_hits   <= '0;
                        r_status <= STAT_OK;
                        r_state  <= S_POP;
                    end
                end
                // Popcount of the input item, one word per cycle
                S_POP: begin
                    r_q <= r_q + POP_W'(w_pop);
                    if (r_w == (WSEL_W+1)'(FP_WORDS - 1)) begin
                        r_state <= S_DISP;
                    end
                    r_w <= r_w + 1'b1;
                end
                S_DISP: begin
                    r_w   <= '0;
                    r_sel <= 1'b0;
                    case (r_item.mode)
                        MODE_LOAD: begin
                            if (r_cnt >= CW'(TABLE_DEPTH)) begin
                                r_status <= STAT_FULL;
                                r_state  <= S_DONE;
                            end else if (r_cnt != '0 && r_q < r_last) begin
                                r_status <= STAT_ORDER;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_LDW;
                            end
                        end
                        MODE_QUERY: r_state <= S_MQ;
                        MODE_CLEAR: begin
                            r_bin_vld <= '0;
                            r_cnt     <= '0;
                            r_last    <= '0;
                            r_state   <= S_DONE;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                // Row write, one word per cycle
                S_LDW: begin
                    if (r_w == (WSEL_W+1)'(FP_WORDS - 1)) begin
                        r_state <= S_LDB_RD;
                    end
                    r_w <= r_w + 1'b1;
                end
                S_LDB_RD: begin
                    r_bv_d  <= r_bin_vld[BW'(r_q)];
                    r_state <= S_LDB_WR;
                end
                S_LDB_WR: begin
                    r_bin_vld[BW'(r_q)] <= 1'b1;
                    r_last  <= r_q;
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= S_DONE;
                end
                // Dividend for the lower (ceil) or upper (floor) bound
                S_MQ: begin
                    r_dvd   <= w_mul[DIV_W-1:0] + (r_sel ? DIV_W'(0) : DIV_W'(w_den_eff - 1'b1));
                    r_rem   <= '0;
                    r_dcnt  <= 5'(DIV_W);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= w_qbit ? CFG_W'(w_trial - {1'b0, w_divisor}) : w_trial[CFG_W-1:0];
                    r_dvd  <= w_quot;
                    r_dcnt <= r_dcnt - 1'b1;
                    if (r_dcnt == 5'd1) begin
                        if (!r_sel) begin
                            r_lo    <= w_quot;
                            r_sel   <= 1'b1;
                            r_state <= S_MQ;
                        end else begin
                            r_hi    <= (w_quot > DIV_W'(FP_BITS)) ? POP_W'(FP_BITS)
                                                                  : POP_W'(w_quot);
                            r_state <= S_WIN;
                        end
                    end
                end
                S_WIN: begin
                    r_begin <= '0;
                    r_end   <= '0;
                    r_p     <= '0;
                    r_pdv   <= 1'b0;
                    r_state <= (r_lo > DIV_W'(r_hi)) ? S_DONE : S_BIN;
                end
                // Prefix sums of the bins up to hi
                S_BIN: begin
                    r_begin <= w_beg_sum;
                    r_end   <= w_end_sum;
                    r_bv_d  <= r_bin_vld[r_p];
                    r_pd    <= r_p;
                    r_pdv   <= 1'b1;
                    r_p     <= r_p + 1'b1;
                    if (r_p == BW'(r_hi)) begin
                        r_state <= S_BIN_TAIL;
                    end
                end
                S_BIN_TAIL: begin
                    r_begin <= w_beg_sum;
                    r_end   <= w_end_sum;
                    r_r     <= w_beg_sum;
                    r_pdv   <= 1'b0;
                    r_state <= S_ROW;
                end
                // Candidate row scan
                S_ROW: begin
                    r_w     <= '0;
                    r_inter <= '0;
                    r_state <= (r_r >= r_end || r_r >= r_cnt) ? S_DONE : S_ACC;
                end
                S_ACC: begin
                    if (r_w != '0) begin
                        r_inter <= r_inter + POP_W'(w_pop);
                    end
                    if (r_w == (WSEL_W+1)'(FP_WORDS)) begin
                        r_state <= S_MA;
                    end else begin
                        r_w <= r_w + 1'b1;
                    end
                end
                S_MA: begin
                    r_pa    <= w_mul;
                    r_uni   <= w_uni;
                    r_state <= S_MB;
                end
                S_MB: begin
                    r_pb    <= w_mul;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_id_rd != r_item.row_id && r_pa >= r_pb) begin
                        r_hits <= r_hits + 1'b1;
                    end
                    r_r     <= r_r + 1'b1;
                    r_state <= S_ROW;
                end
                S_DONE: begin
                    r_res_vld         <= 1'b1;
                    r_res.hit_count   <= OUT_CNT_W'(r_hits);
                    r_res.status      <= r_status;
                    r_res.rows_stored <= OUT_CNT_W'(r_cnt);
                    r_state           <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_res_vld;
    assign o_result       = r_res;

endmodule

@@ sim/testbench.sv @@
// Testbench for the Tanimoto threshold hit counter: directed and random checks.
`timescale 1ns / 100ps

module testbench;
    import tthc_pkg::*;

    localparam int          DEPTH    = TABLE_DEPTH_DEF;
    localparam logic [1:0]  MODE_NOP = 2'd3;
    localparam logic [2:0]  ADDR_NUM = 3'd0;
    localparam logic [2:0]  ADDR_DEN = 3'd4;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in         i_item;
    logic        o_result_valid;
    t_out        o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tanimoto_threshold_hit_counter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Shadow of the table and threshold
    logic [255:0] row_fp [DEPTH];
    logic [63:0]  row_key [DEPTH];
    int           row_pop [DEPTH];
    int           pop_bins [FP_BITS + 1];
    int           rows_held;
    int           last_pop;
    int           thr_num;
    int           thr_den;

    t_out expected_results [$];
    int   mismatches;
    int   idle_pct;

    function automatic logic [255:0] fp_of(t_in it);
        return {it.fp_word_3, it.fp_word_2, it.fp_word_1, it.fp_word_0};
    endfunction

    // Compute the result of one item and advance the shadow state
    function automatic t_out score_item(t_in it);
        t_out         res;
        logic [255:0] fp;
        int           q, lo, hi, first, last, hits, inter, uni, n, d;
        fp   = fp_of(it);
        q    = $countones(fp);
        hits = 0;
        res.status = STAT_OK;
        case (it.mode)
            MODE_LOAD: begin
                if (rows_held >= DEPTH) begin
                    res.status = STAT_FULL;
                end else if (rows_held > 0 && q < last_pop) begin
                    res.status = STAT_ORDER;
                end else begin
                    row_fp[rows_held]  = fp;
                    row_key[rows_held] = it.row_id;
                    row_pop[rows_held] = q;
                    pop_bins[q]++;
                    last_pop = q;
                    rows_held++;
                end
            end
            MODE_QUERY: begin
                n     = (thr_num == 0) ? 1 : thr_num;
                d     = (thr_den == 0) ? 1 : thr_den;
                lo    = (n * q + d - 1) / d;
                hi    = (d * q) / n;
                first = 0;
                last  = 0;
                if (hi > FP_BITS) hi = FP_BITS;
                if (lo <= hi) begin
                    for (int p = 0; p < lo; p++) first += pop_bins[p];
                    last = first;
                    for (int p = lo; p <= hi; p++) last += pop_bins[p];
                end
                if (last > rows_held) last = rows_held;
                for (int r = first; r < last; r++) begin
                    if (row_key[r] != it.row_id) begin
                        inter = $countones(fp & row_fp[r]);
                        uni   = q + row_pop[r] - inter;
                        if (uni == 0) uni = 1;
                        if (inter * d >= uni * n) hits++;
                    end
                end
            end
            MODE_CLEAR: begin
                foreach (pop_bins[p]) pop_bins[p] = 0;
                rows_held = 0;
                last_pop  = 0;
            end
            default: ;
        endcase
        res.hit_count   = OUT_CNT_W'(hits);
        res.rows_stored = OUT_CNT_W'(rows_held);
        return res;
    endfunction

    // Result checker: the receiver cannot stall, so every strobe is a transfer
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_result_valid) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: hit=%0d status=%0d rows=%0d",
                             o_result.hit_count, o_result.status, o_result.rows_stored);
            end else begin
                want = expected_results.pop_front();
                if (o_result.hit_count !== want.hit_count || o_result.status !== want.status
                    || o_result.rows_stored !== want.rows_stored) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: hit exp %0d got %0d, status exp %0d got %0d,",
                                  " rows exp %0d got %0d"},
                                 want.hit_count, o_result.hit_count, want.status,
                                 o_result.status, want.rows_stored, o_result.rows_stored);
                end
            end
        end
    end

    // Send one command; start stays high across back-to-back transfers
    task automatic send_item(t_in it);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        expected_results.insert(expected_results.size(), score_item(it));
    endtask

    // Stop sending and wait for every pending result
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_NUM) thr_num = int'(data[9:0]);
        else                  thr_den = int'(data[9:0]);
    endtask

    task automatic set_threshold(int n, int d);
        drain();
        write_reg(ADDR_NUM, {$urandom_range(32'h3f_ffff), 10'(n)});
        write_reg(ADDR_DEN, {$urandom_range(32'h3f_ffff), 10'(d)});
    endtask

    function automatic logic [255:0] fp_with_pop(int k);
        logic [255:0] v;
        v = (k > 128) ? '1 : '0;
        while ($countones(v) != k) v[$urandom_range(255)] = (k <= 128);
        return v;
    endfunction

    function automatic t_in make_item(logic [1:0] mode, logic [63:0] key, logic [255:0] fp);
        t_in it;
        it.mode      = mode;
        it.row_id    = key;
        it.fp_word_0 = fp[63:0];
        it.fp_word_1 = fp[127:64];
        it.fp_word_2 = fp[191:128];
        it.fp_word_3 = fp[255:192];
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_cfg();
        case ($urandom_range(5))
            0:       return 0;
            1:       return 1;
            2:       return 1023;
            3:       return 7;
            4:       return 10;
            default: return $urandom_range(1023);
        endcase
    endfunction

    // Edge cases: extremes, every mode, self exclusion, order and zero registers
    task automatic test_directed();
        logic [255:0] ones;
        ones = '1;
        idle_pct = 0;
        send_item(make_item(MODE_QUERY, 64'd0, '0));
        send_item(make_item(MODE_LOAD, 64'd0, '0));
        send_item(make_item(MODE_LOAD, 64'd1, '0));
        send_item(make_item(MODE_LOAD, '1, fp_with_pop(200)));
        send_item(make_item(MODE_LOAD, 64'd5, ones));
        send_item(make_item(MODE_LOAD, 64'd6, fp_with_pop(100)));
        send_item(make_item(MODE_NOP, '1, ones));
        send_item(make_item(MODE_QUERY, 64'd5, ones));
        send_item(make_item(MODE_QUERY, 64'd9, ones));
        send_item(make_item(MODE_QUERY, 64'd0, '0));
        send_item(make_item(MODE_QUERY, '1, fp_with_pop(190)));
        set_threshold(0, 0);
        send_item(make_item(MODE_QUERY, 64'd2, ones));
        send_item(make_item(MODE_QUERY, 64'd2, '0));
        set_threshold(1023, 1);
        send_item(make_item(MODE_QUERY, 64'd3, fp_with_pop(3)));
        set_threshold(1, 1023);
        send_item(make_item(MODE_QUERY, 64'd3, fp_with_pop(1)));
        send_item(make_item(MODE_QUERY, 64'd4, fp_with_pop(255)));
        send_item(make_item(MODE_CLEAR, '1, ones));
        send_item(make_item(MODE_QUERY, 64'd5, ones));
        send_item(make_item(MODE_LOAD, 64'd7, fp_with_pop(50)));
        drain();
    endtask

    // Random traffic: mostly sorted loads with queries near stored rows
    task automatic test_random(int count, int pct);
        t_in          it;
        logic [255:0] fp;
        logic [63:0]  key;
        int           sel, k, r;
        idle_pct = pct;
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 63) set_threshold(pick_cfg(), pick_cfg());
            sel = $urandom_range(99);
            key = rand64();
            if (sel < 6 || rows_held > 40) begin
                it = make_item(MODE_CLEAR, key, {rand64(), rand64(), rand64(), rand64()});
            end else if (sel < 50) begin
                k = last_pop + $urandom_range(0, 10);
                if ($urandom_range(9) == 0 && last_pop > 0) k = $urandom_range(last_pop - 1);
                if (rows_held == 0) k = $urandom_range(FP_BITS);
                if (k > FP_BITS) k = FP_BITS;
                if (rows_held > 0 && $urandom_range(4) == 0)
                    key = row_key[$urandom_range(rows_held - 1)];
                it = make_item(MODE_LOAD, key, fp_with_pop(k));
            end else if (sel < 92) begin
                if (rows_held > 0 && $urandom_range(4) != 0) begin
                    r  = $urandom_range(rows_held - 1);
                    fp = row_fp[r];
                    repeat ($urandom_range(0, 6)) fp[$urandom_range(255)] ^= 1'b1;
                    if ($urandom_range(2) == 0) key = row_key[r];
                end else begin
                    fp = fp_with_pop($urandom_range(FP_BITS));
                end
                it = make_item(MODE_QUERY, key, fp);
            end else begin
                it = make_item(MODE_NOP, key, {rand64(), rand64(), rand64(), rand64()});
            end
            send_item(it);
        end
        drain();
    endtask

    // Run limit
    initial begin
        #60_000_000;
        $display("** tanimoto_threshold_hit_counter: FAILED **");
        $finish;
    end

    initial begin
        start      <= 1'b0;
        i_item     <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        i_rst_n    <= 1'b0;
        mismatches = 0;
        idle_pct   = 0;
        rows_held  = 0;
        last_pop   = 0;
        thr_num    = 7;
        thr_den    = 10;
        foreach (pop_bins[p]) pop_bins[p] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        test_directed();
        set_threshold(7, 10);
        test_random(195, 36);
        set_threshold(1023, 1023);
        test_random(195, 86);
        set_threshold(pick_cfg(), pick_cfg());
        test_random(195, 0);

        drain();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("** tanimoto_threshold_hit_counter: PASSED **");
        end else begin
            $display("** tanimoto_threshold_hit_counter: FAILED **");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/tthc_pkg.sv
hw/rtl/tanimoto_threshold_hit_counter.sv
sim/testbench.sv
